// ===== src/streaming_source_lexer_macros.svh =====
// ----------------------------------------------------------------------------
// Lexer assertion macros
// Assertion macros for the lexer blocks; the token emitter uses them.
// ----------------------------------------------------------------------------
`ifndef STREAMING_SOURCE_LEXER_MACROS_SVH
`define STREAMING_SOURCE_LEXER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SSL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SSL_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define SSL_ASSERT(lbl, clk, rstn, prop, msg)
`define SSL_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== src/ssl_pkg.sv =====
// ----------------------------------------------------------------------------
// Lexer package
// Types, token kinds and character classes shared by the lexer modules.
// ----------------------------------------------------------------------------
package ssl_pkg;

  localparam int unsigned PosBits  = 32;
  localparam int unsigned LineBits = 24;
  localparam int unsigned LenBits  = 16;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_OP, MODE_NUM, MODE_IDENT, MODE_STR, MODE_LINEC, MODE_BLOCKC
  } mode_e;

  localparam logic [5:0] KNumber   = 6'd13;
  localparam logic [5:0] KIdent    = 6'd14;
  localparam logic [5:0] KStrLit   = 6'd15;
  localparam logic [5:0] KUnclosed = 6'd16;
  localparam logic [5:0] KUnident  = 6'd46;
  localparam logic [5:0] KEof      = 6'd47;

  typedef struct packed {
    logic [5:0]          kind;
    logic [LineBits-1:0] line;
    logic [PosBits-1:0]  start_pos;
    logic [LenBits-1:0]  length;
    logic                last;
  } token_t;

  typedef struct packed {
    logic   two;
    token_t t0;
    token_t t1;
  } pair_t;

  function automatic logic is_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_istart(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
  endfunction

  function automatic logic is_op(logic [7:0] b);
    return b inside {"+", "-", "*", "%", "^", "!", ">", "=", "<", "/"};
  endfunction

  function automatic logic [5:0] single_op(logic [7:0] b);
    logic [5:0] k;
    case (b)
      "+": k = 6'd27;
      "-": k = 6'd28;
      "*": k = 6'd29;
      "/": k = 6'd30;
      "%": k = 6'd31;
      "^": k = 6'd32;
      "=": k = 6'd33;
      "<": k = 6'd34;
      ">": k = 6'd35;
      "!": k = 6'd36;
      default: k = KUnident;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] assign_op(logic [7:0] b);
    logic [5:0] k;
    case (b)
      "+": k = 6'd37;
      "-": k = 6'd38;
      "*": k = 6'd39;
      "%": k = 6'd40;
      "^": k = 6'd41;
      "!": k = 6'd42;
      ">": k = 6'd43;
      "=": k = 6'd44;
      "<": k = 6'd45;
      default: k = KUnident;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] punct(logic [7:0] b);
    logic [5:0] k;
    case (b)
      "(": k = 6'd17;
      ")": k = 6'd18;
      "[": k = 6'd19;
      "]": k = 6'd20;
      "{": k = 6'd21;
      "}": k = 6'd22;
      ":": k = 6'd23;
      ";": k = 6'd24;
      ",": k = 6'd25;
      ".": k = 6'd26;
      default: k = 6'd0;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] word_kind(logic [47:0] w, logic [LenBits-1:0] n);
    logic [5:0] k;
    k = KIdent;
    case (n)
      LenBits'(2): begin
        if (w[15:0] == "fn") k = 6'd0;
        if (w[15:0] == "if") k = 6'd1;
      end
      LenBits'(3): begin
        if (w[23:0] == "for") k = 6'd3;
        if (w[23:0] == "nth") k = 6'd8;
        if (w[23:0] == "int") k = 6'd9;
      end
      LenBits'(4): begin
        if (w[31:0] == "else") k = 6'd4;
        if (w[31:0] == "list") k = 6'd7;
        if (w[31:0] == "void") k = 6'd12;
      end
      LenBits'(5): begin
        if (w[39:0] == "while") k = 6'd2;
        if (w[39:0] == "float") k = 6'd10;
      end
      LenBits'(6): begin
        if (w == "return") k = 6'd5;
        if (w == "defvar") k = 6'd6;
        if (w == "string") k = 6'd11;
      end
      default: k = KIdent;
    endcase
    return k;
  endfunction

endpackage

// ===== src/ssl_scan.sv =====
// ----------------------------------------------------------------------------
// Lexer scanner
// Accepts bytes, updates the scan state and produces zero to two tokens.
// ----------------------------------------------------------------------------
module ssl_scan import ssl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] ch_i,
  output logic       pair_valid_o,
  input  logic       pair_ready_i,
  output pair_t      pair_o
);

  mode_e               mode_q, mode_d;
  logic [7:0]          pend_q, pend_d, quote_q, quote_d;
  logic                star_q, star_d;
  logic [47:0]         word_q, word_d;
  logic [LenBits-1:0]  len_q, len_d;
  logic [PosBits-1:0]  start_q, start_d, pos_q;
  logic [LineBits-1:0] tline_q, tline_d, cline_q, cline_d;
  logic                ov_q;
  pair_t               pr_q, pr_d;
  token_t              em [2];
  logic [1:0]          n;
  logic                fire;

  assign in_ready_o   = !ov_q || pair_ready_i;
  assign fire         = in_valid_i && in_ready_o;
  assign pair_valid_o = ov_q;
  assign pair_o       = pr_q;

  function automatic logic [LenBits-1:0] inc_len(logic [LenBits-1:0] v);
    return (v == '1) ? v : v + LenBits'(1);
  endfunction

  always_comb begin
    logic [5:0]          ck;
    logic                have;
    logic                do_close, do_fresh;
    logic [LineBits-1:0] cl;
    mode_d = mode_q; pend_d = pend_q; quote_d = quote_q; star_d = star_q;
    word_d = word_q; len_d = len_q; start_d = start_q; tline_d = tline_q;
    cl = cline_q; n = 2'd0; do_close = 1'b0; do_fresh = 1'b0;
    em[0] = '0; em[1] = '0;
    ck = KIdent; have = 1'b0;
    case (mode_q)
      MODE_OP:    begin ck = single_op(pend_q); have = 1'b1; end
      MODE_NUM:   begin ck = KNumber; have = 1'b1; end
      MODE_IDENT: begin
        ck = (len_q > LenBits'(6)) ? KIdent : word_kind(word_q, len_q); have = 1'b1;
      end
      MODE_STR:   begin ck = KUnclosed; have = 1'b1; end
      default:    have = 1'b0;
    endcase
    if (op_i) begin
      if (have) begin
        em[0] = '{ck, tline_q, start_q, len_q, 1'b0}; n = 2'd1;
      end
      em[n[0]] = '{KEof, cline_q, pos_q, '0, 1'b1};
      n = n + 2'd1;
    end else begin
      case (mode_q)
        MODE_OP: begin
          if (ch_i == "=" && pend_q != "/") begin
            em[0] = '{assign_op(pend_q), tline_q, start_q, LenBits'(2), 1'b0};
            n = 2'd1; mode_d = MODE_IDLE;
          end else if (pend_q == "-" && is_digit(ch_i)) begin
            mode_d = MODE_NUM; len_d = inc_len(len_q);
          end else if (pend_q == "/" && ch_i == "/") begin
            mode_d = MODE_LINEC;
          end else if (pend_q == "/" && ch_i == "*") begin
            mode_d = MODE_BLOCKC; star_d = 1'b1;
          end else begin
            do_close = 1'b1; do_fresh = 1'b1;
          end
        end
        MODE_NUM: begin
          if (is_digit(ch_i) || ch_i == "." || ch_i == "-") len_d = inc_len(len_q);
          else begin do_close = 1'b1; do_fresh = 1'b1; end
        end
        MODE_IDENT: begin
          if (is_istart(ch_i) || is_digit(ch_i)) begin
            if (len_q < LenBits'(6)) word_d = {word_q[39:0], ch_i};
            len_d = inc_len(len_q);
          end else begin do_close = 1'b1; do_fresh = 1'b1; end
        end
        MODE_STR: begin
          len_d = inc_len(len_q);
          if (ch_i == quote_q) begin
            em[0] = '{KStrLit, tline_q, start_q, inc_len(len_q), 1'b0};
            n = 2'd1; mode_d = MODE_IDLE;
          end
        end
        MODE_LINEC: begin
          if (ch_i == 8'h0a) begin
            mode_d = MODE_IDLE;
            if (cl != '1) cl = cl + LineBits'(1);
          end
        end
        MODE_BLOCKC: begin
          if (ch_i == 8'h0a && cl != '1) cl = cl + LineBits'(1);
          if (star_q && ch_i == "/") begin
            mode_d = MODE_IDLE; star_d = 1'b0;
          end else star_d = (ch_i == "*");
        end
        default: do_fresh = 1'b1;
      endcase
      if (do_close) begin
        if (have) begin em[0] = '{ck, tline_q, start_q, len_q, 1'b0}; n = 2'd1; end
        mode_d = MODE_IDLE; star_d = 1'b0;
      end
      if (do_fresh) begin
        mode_d = MODE_IDLE;
        if (ch_i == "'" || ch_i == "\"") begin
          mode_d = MODE_STR; quote_d = ch_i;
          start_d = pos_q; tline_d = cl; len_d = LenBits'(1);
        end else if (ch_i == 8'h0a) begin
          if (cl != '1) cl = cl + LineBits'(1);
        end else if (ch_i inside {8'h20, 8'h09, 8'h0b, 8'h0c, 8'h0d}) begin
        end else if (punct(ch_i) != 6'd0) begin
          em[n[0]] = '{punct(ch_i), cl, pos_q, LenBits'(1), 1'b0}; n = n + 2'd1;
        end else if (is_digit(ch_i)) begin
          mode_d = MODE_NUM; start_d = pos_q; tline_d = cl; len_d = LenBits'(1);
        end else if (is_op(ch_i)) begin
          mode_d = MODE_OP; pend_d = ch_i;
          start_d = pos_q; tline_d = cl; len_d = LenBits'(1);
        end else if (is_istart(ch_i)) begin
          mode_d = MODE_IDENT; word_d = {40'd0, ch_i};
          start_d = pos_q; tline_d = cl; len_d = LenBits'(1);
        end else begin
          em[n[0]] = '{KUnident, cl, pos_q, LenBits'(1), 1'b0}; n = n + 2'd1;
        end
      end
      if (n == 2'd1) em[0].last = 1'b1;
      if (n == 2'd2) em[1].last = 1'b1;
    end
    cline_d = cl;
    pr_d = '{(n == 2'd2), em[0], em[1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE; pend_q <= '0; quote_q <= '0; star_q <= 1'b0;
      word_q <= '0; len_q <= '0; start_q <= '0; tline_q <= LineBits'(1);
      cline_q <= LineBits'(1); pos_q <= '0; ov_q <= 1'b0;
    end else begin
      if (pair_ready_i) ov_q <= 1'b0;
      if (fire) begin
        if (n != 2'd0) ov_q <= 1'b1;
        if (op_i) begin
          mode_q <= MODE_IDLE; pend_q <= '0; quote_q <= '0; star_q <= 1'b0;
          word_q <= '0; len_q <= '0; start_q <= '0; tline_q <= LineBits'(1);
          cline_q <= LineBits'(1); pos_q <= '0;
        end else begin
          mode_q <= mode_d; pend_q <= pend_d; quote_q <= quote_d; star_q <= star_d;
          word_q <= word_d; len_q <= len_d; start_q <= start_d; tline_q <= tline_d;
          cline_q <= cline_d; pos_q <= pos_q + PosBits'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && n != 2'd0) pr_q <= pr_d;
  end

endmodule

// ===== src/ssl_emit.sv =====
// ----------------------------------------------------------------------------
// Lexer token emitter
// Sends the scanner's token pair one word per cycle while pair_valid_i and out_ready_i are high.
// ----------------------------------------------------------------------------
module ssl_emit import ssl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pair_valid_i,
  output logic                pair_ready_o,
  input  pair_t               pair_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [5:0]          kind_o,
  output logic [LineBits-1:0] line_o,
  output logic [PosBits-1:0]  start_pos_o,
  output logic [LenBits-1:0]  length_o,
  output logic                last_o
);
  `include "streaming_source_lexer_macros.svh"

  logic  sel_q;
  token_t t;

  assign out_valid_o  = pair_valid_i;
  assign t            = sel_q ? pair_i.t1 : pair_i.t0;
  assign pair_ready_o = out_ready_i && (sel_q || !pair_i.two);
  assign kind_o       = t.kind;
  assign line_o       = t.line;
  assign start_pos_o  = t.start_pos;
  assign length_o     = t.length;
  assign last_o       = t.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (pair_valid_i && out_ready_i) begin
      sel_q <= pair_i.two && !sel_q;
    end
  end

  `SSL_ASSERT(a_sel_two, clk_i, rst_ni, sel_q |-> pair_valid_i && pair_i.two, "second slot bad")
  `SSL_ASSERT(a_last, clk_i, rst_ni, pair_ready_o && pair_valid_i |-> last_o, "last missing")
  `SSL_ASSERT_NEVER(a_first, clk_i, rst_ni, pair_valid_i && pair_i.two && !sel_q && last_o, "early last")

endmodule

// ===== src/streaming_source_lexer.sv =====
// Output: each token is held in the scanner's pair register before it leaves.
// Throughput: one byte per cycle unless output is held; a two-token byte holds input.
// Reset: asynchronous active low; line restarts at one and position at zero.
// ----------------------------------------------------------------------------
// Streaming source lexer
// Turns a byte stream into tokens with kind, line, offset and length.
// ----------------------------------------------------------------------------
module streaming_source_lexer import ssl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                op_i,
  input  logic [7:0]          ch_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [5:0]          kind_o,
  output logic [LineBits-1:0] line_o,
  output logic [PosBits-1:0]  start_pos_o,
  output logic [LenBits-1:0]  length_o,
  output logic                last_o
);

  logic  pv, pr;
  pair_t p;

  ssl_scan u_scan (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .ch_i,
    .pair_valid_o(pv), .pair_ready_i(pr), .pair_o(p)
  );

  ssl_emit u_emit (
    .clk_i, .rst_ni, .pair_valid_i(pv), .pair_ready_o(pr), .pair_i(p),
    .out_valid_o, .out_ready_i, .kind_o, .line_o, .start_pos_o, .length_o, .last_o
  );

endmodule
